>>> rtl/core/prf_pkg.sv
package prf_pkg;

	localparam int FRAME_ENTRIES = 64;
	localparam int PAGE_BITS     = 20;
	localparam int IDX_W         = $clog2(FRAME_ENTRIES);
	localparam int CAP_W         = $clog2(FRAME_ENTRIES + 1);

	localparam int S_TDATA_W = ((PAGE_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = CAP_W;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(1);

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(FRAME_ENTRIES);

	typedef struct packed {
		logic load;
		logic match;
		logic select;
		logic update;
	} prf_cmd_t;

	typedef struct packed {
		logic hit;
	} prf_status_t;

endpackage

>>> rtl/core/prf_datapath.sv
module prf_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  prf_pkg::prf_cmd_t                      cmd,
	output prf_pkg::prf_status_t                   status,
	input  logic [prf_pkg::PAGE_BITS-1:0]          page_in,
	input  logic                                   cfg_we,
	input  logic [prf_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [prf_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int N = prf_pkg::FRAME_ENTRIES;
	localparam logic [N-1:0] ONE_V = N'(1);

	logic [prf_pkg::PAGE_BITS-1:0] page_q;
	logic [prf_pkg::PAGE_BITS-1:0] tag_q [N];
	logic [N-1:0]                  valid_q;
	logic [prf_pkg::IDX_W-1:0]     rank_q [N];
	logic [N-1:0]                  match_q;
	logic [N-1:0]                  evict_q;
	logic                          hit_q;
	logic [prf_pkg::IDX_W-1:0]     hit_rank_q;
	logic                          policy_q;
	logic [prf_pkg::CAP_W-1:0]     capacity_q;

	logic [prf_pkg::CAP_W-1:0]     cap_used;
	logic [prf_pkg::IDX_W-1:0]     cap_m1;
	logic [prf_pkg::IDX_W-1:0]     hit_rank;
	logic [N-1:0]                  free_v;
	logic [N-1:0]                  first_free;

	always_comb begin
		if (capacity_q == '0) begin
			cap_used = prf_pkg::CAP_W'(1);
		end else if (capacity_q > prf_pkg::CAP_W'(N)) begin
			cap_used = prf_pkg::CAP_W'(N);
		end else begin
			cap_used = capacity_q;
		end
		cap_m1 = prf_pkg::IDX_W'(cap_used - prf_pkg::CAP_W'(1));
	end

	// rank of the matching frame, at most one match
	always_comb begin
		hit_rank = '0;
		for (int i = 0; i < N; i++) begin
			if (match_q[i]) begin
				hit_rank = hit_rank | rank_q[i];
			end
		end
	end

	// lowest frame left free after eviction
	assign free_v     = ~(valid_q & ~evict_q);
	assign first_free = free_v & (~free_v + ONE_V);

	assign status.hit = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q   <= prf_pkg::POLICY_FIFO;
			capacity_q <= prf_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				prf_pkg::REG_POLICY:   policy_q   <= cfg_data[0];
				prf_pkg::REG_CAPACITY: capacity_q <= cfg_data[prf_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= page_in;
		end
		if (cmd.select) begin
			hit_rank_q <= hit_rank;
		end
		for (int i = 0; i < N; i++) begin
			if (cmd.update && !hit_q && first_free[i]) begin
				tag_q[i] <= page_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			match_q <= '0;
			evict_q <= '0;
			hit_q   <= 1'b0;
			for (int i = 0; i < N; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cmd.match) begin
				for (int i = 0; i < N; i++) begin
					match_q[i] <= valid_q[i] && (tag_q[i] == page_q);
				end
			end
			if (cmd.select) begin
				hit_q <= |match_q;
				for (int i = 0; i < N; i++) begin
					evict_q[i] <= valid_q[i] && (rank_q[i] >= cap_m1);
				end
			end
			if (cmd.update) begin
				if (hit_q) begin
					if (policy_q == prf_pkg::POLICY_LRU) begin
						for (int i = 0; i < N; i++) begin
							if (match_q[i]) begin
								rank_q[i] <= '0;
							end else if (valid_q[i] && rank_q[i] < hit_rank_q) begin
								rank_q[i] <= rank_q[i] + prf_pkg::IDX_W'(1);
							end
						end
					end
				end else begin
					for (int i = 0; i < N; i++) begin
						if (evict_q[i]) begin
							valid_q[i] <= 1'b0;
							rank_q[i]  <= '0;
						end else if (valid_q[i]) begin
							rank_q[i] <= rank_q[i] + prf_pkg::IDX_W'(1);
						end
						if (first_free[i]) begin
							valid_q[i] <= 1'b1;
							rank_q[i]  <= '0;
						end
					end
				end
			end
		end
	end

	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_q))
		else $error("page held in more than one frame");

	a_hit_has_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && hit_q |-> match_q != '0)
		else $error("hit with no matching frame");

	a_miss_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && !hit_q |-> first_free != '0)
		else $error("miss found no free frame");

endmodule

>>> rtl/core/prf_ctrl.sv
module prf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic                  out_hit,
	output prf_pkg::prf_cmd_t     cmd,
	input  prf_pkg::prf_status_t  status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_SELECT,
		S_UPDATE,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_hit_q;
	logic   out_free;

	assign out_free   = !out_valid_q || m_tready;
	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = out_valid_q;
	assign out_hit    = out_hit_q;

	assign cmd.load   = (state_q == S_IDLE) && s_tvalid;
	assign cmd.match  = (state_q == S_MATCH);
	assign cmd.select = (state_q == S_SELECT);
	assign cmd.update = (state_q == S_UPDATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH:  state_q <= S_SELECT;
				S_SELECT: state_q <= S_UPDATE;
				S_UPDATE, S_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_hit_q   <= status.hit;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_HOLD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |-> ##4 m_tvalid)
		else $error("result not delivered after lookup");

endmodule

>>> rtl/core/page_replacement_fifo_lru.sv
// Fully associative page cache with 64 frames and FIFO or LRU replacement.
// Each beat on s_axis carries one page number; one beat on m_axis returns
// its hit flag, in order. From acceptance to its result being loaded into
// the output register, a page goes through the parallel tag compare across
// all frames, then hit and eviction selection, then the age-rank update;
// the next page is accepted the cycle after that update has handed its
// result to the output register, so no page is taken while one is in flight.
// A result held by m_tready low keeps the block in its final step until the
// output register frees up.
// Write replace_policy (index 0) and frame_capacity (index 1) only while idle.
module page_replacement_fifo_lru (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [prf_pkg::S_TDATA_W-1:0]      s_tdata,   // [19:0] page_number
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [prf_pkg::M_TDATA_W-1:0]      m_tdata,   // [0] hit
	input  logic                               cfg_we,
	input  logic [prf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [prf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	prf_pkg::prf_cmd_t    cmd;
	prf_pkg::prf_status_t status;
	logic                 out_hit;

	assign m_tdata = prf_pkg::M_TDATA_W'(out_hit);

	prf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.out_hit  (out_hit),
		.cmd      (cmd),
		.status   (status)
	);

	prf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.page_in   (s_tdata[prf_pkg::PAGE_BITS-1:0]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
